// ===== sv/kwsd_pkg.sv =====
// package for the keyed word stream decryptor
// widths, mixing constants and the key table built at elaboration; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package kwsd_pkg;

    localparam int WORD_W      = 32;
    localparam int TABLE_DEPTH = 256;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

    localparam logic [WORD_W-1:0] MIXER_INIT = 32'hEEEE_EEEE;
    localparam logic [WORD_W-1:0] KEY_ADD    = 32'h1111_1111;
    localparam logic [WORD_W-1:0] MIX_ADD    = 32'd3;

    // table generator: linear congruential, five pairs of draws per entry
    localparam logic [31:0] GEN_SEED  = 32'h0010_0001;
    localparam logic [31:0] GEN_MUL   = 32'd125;
    localparam logic [31:0] GEN_INC   = 32'd3;
    localparam logic [31:0] GEN_MOD   = 32'h002A_AAAB;
    localparam int          GEN_PAIRS = 5;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [TABLE_AW-1:0] table_addr_t;
    typedef word_t key_table_t [TABLE_DEPTH];

    // entry i keeps the last of its five pairs
    function automatic key_table_t build_key_table();
        key_table_t  tbl;
        logic [31:0] seed;
        logic [31:0] hi;
        seed = GEN_SEED;
        hi   = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            for (int g = 0; g < GEN_PAIRS; g++)
            begin
                seed = 32'((seed * GEN_MUL + GEN_INC) % GEN_MOD);
                hi   = {seed[15:0], 16'h0000};
                seed = 32'((seed * GEN_MUL + GEN_INC) % GEN_MOD);
                if (g == GEN_PAIRS - 1)
                begin
                    tbl[i] = hi | {16'h0000, seed[15:0]};
                end
            end
        end
        return tbl;
    endfunction

    localparam key_table_t KEY_TABLE = build_key_table();

endpackage

`default_nettype wire

// ===== sv/kwsd_in_if.sv =====
// input channel of the keyed word stream decryptor
// valid/ready handshake with cipher word, start flag and block key; uses kwsd_pkg
`timescale 1ns / 1ps
`default_nettype none

interface kwsd_in_if;
    logic           valid;
    logic           ready;
    kwsd_pkg::word_t cipher_word;
    logic           start_req;
    kwsd_pkg::word_t block_key;

    modport source (output valid, output cipher_word, output start_req,
                    output block_key, input ready);
    modport sink   (input valid, input cipher_word, input start_req,
                    input block_key, output ready);
endinterface

`default_nettype wire

// ===== sv/kwsd_out_if.sv =====
// output channel of the keyed word stream decryptor
// valid/ready handshake with the plain word; uses kwsd_pkg
`timescale 1ns / 1ps
`default_nettype none

interface kwsd_out_if;
    logic           valid;
    logic           ready;
    kwsd_pkg::word_t plain_word;

    modport source (output valid, output plain_word, input ready);
    modport sink   (input valid, input plain_word, output ready);
endinterface

`default_nettype wire

// ===== sv/kwsd_ram.sv =====
// generic single write port, single read port ram with registered read
// standalone, no package dependency
`timescale 1ns / 1ps
`default_nettype none

module kwsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/keyed_word_stream_decrypt_top.sv =====
// keyed word stream decryptor, top level
// uses kwsd_pkg, kwsd_in_if, kwsd_out_if and kwsd_ram
// path: an accepted word is registered in the mix stage while the key table ram
//   is read, then its plain word is registered in the output register
// throughput: one word per cycle unless stalled; the key loop closes in the
//   accept stage, the mixer loop in the stage after the key table ram read
// reset: key clears to zero, mixer to 0xEEEEEEEE; after reset the key table ram
//   is filled from the constant table with input ready held low until it is full
`timescale 1ns / 1ps
`default_nettype none

module keyed_word_stream_decrypt_top (
    input  wire logic clk,
    input  wire logic rst_n,
    kwsd_in_if.sink   cipher_in,
    kwsd_out_if.source plain_out
);

    // table fill after reset
    kwsd_pkg::table_addr_t fill_idx_reg;
    logic                  fill_done_reg;

    // accept stage: running key for the next item
    kwsd_pkg::word_t key_reg;
    kwsd_pkg::word_t key_eff;
    kwsd_pkg::word_t key_next;

    // mix stage: item waiting on the table read
    logic            s1_valid_reg;
    logic            s1_start_reg;
    kwsd_pkg::word_t s1_key_reg;
    kwsd_pkg::word_t s1_cipher_reg;

    // mixer state and its update path
    kwsd_pkg::word_t mixer_reg;
    kwsd_pkg::word_t mix_base;
    kwsd_pkg::word_t mix_sum;
    kwsd_pkg::word_t mixer_next;
    kwsd_pkg::word_t plain_calc;
    kwsd_pkg::word_t table_q;

    // output register
    logic            out_valid_reg;
    kwsd_pkg::word_t out_word_reg;

    // pipeline flow control
    logic out_free;
    logic s1_free;
    logic s1_move;
    logic accept;

    assign out_free = !out_valid_reg || plain_out.ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s1_free  = !s1_valid_reg || out_free;
    assign cipher_in.ready = fill_done_reg && s1_free;
    assign accept   = cipher_in.valid && cipher_in.ready;

    // key loop: a start word loads the block key before use
    always_comb
    begin
        key_eff  = cipher_in.start_req ? cipher_in.block_key : key_reg;
        key_next = ((~key_eff) << 21) + kwsd_pkg::KEY_ADD | (key_eff >> 11);
    end

    // table read is issued on accept so data holds through a stall
    kwsd_ram #(
        .WIDTH (kwsd_pkg::WORD_W),
        .DEPTH (kwsd_pkg::TABLE_DEPTH)
    ) u_key_table (
        .clk   (clk),
        .we    (!fill_done_reg),
        .waddr (fill_idx_reg),
        .wdata (kwsd_pkg::KEY_TABLE[fill_idx_reg]),
        .re    (accept),
        .raddr (key_eff[kwsd_pkg::TABLE_AW-1:0]),
        .rdata (table_q)
    );

    // mixer loop: table add, decrypt, then fold the plain word back in
    always_comb
    begin
        mix_base   = s1_start_reg ? kwsd_pkg::MIXER_INIT : mixer_reg;
        mix_sum    = mix_base + table_q;
        plain_calc = s1_cipher_reg ^ (s1_key_reg + mix_sum);
        mixer_next = plain_calc + mix_sum + (mix_sum << 5) + kwsd_pkg::MIX_ADD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_idx_reg  <= '0;
            fill_done_reg <= 1'b0;
        end
        else if (!fill_done_reg)
        begin
            fill_idx_reg <= fill_idx_reg + 1'b1;
            if (fill_idx_reg == kwsd_pkg::table_addr_t'(kwsd_pkg::TABLE_DEPTH - 1))
            begin
                fill_done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg       <= '0;
            mixer_reg     <= kwsd_pkg::MIXER_INIT;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                key_reg <= key_next;
            end
            if (s1_free)
            begin
                s1_valid_reg <= accept;
            end
            if (s1_move)
            begin
                mixer_reg <= mixer_next;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_move;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_start_reg  <= cipher_in.start_req;
            s1_key_reg    <= key_eff;
            s1_cipher_reg <= cipher_in.cipher_word;
        end
        if (s1_move)
        begin
            out_word_reg <= plain_calc;
        end
    end

    assign plain_out.valid      = out_valid_reg;
    assign plain_out.plain_word = out_word_reg;

    // no item enters while the table is still being filled
    assert property (@(posedge clk) disable iff (!rst_n)
        !fill_done_reg |-> !cipher_in.ready)
        else $error("item accepted during table fill");

    // an accepted item always reaches the mix stage
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted item lost before mix stage");

    // a blocked mix stage keeps its item
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_free |=> s1_valid_reg)
        else $error("mix stage dropped a stalled item");

    // a new result only comes from the mix stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result appeared without an item in the mix stage");

    // the mixer only moves when a result is produced
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(s1_move) && !$past(!rst_n) |-> $stable(mixer_reg))
        else $error("mixer changed without a result");

endmodule

`default_nettype wire
